[sv/rgb_cmy_hsb_color_converter_defines.svh]
// assertion helpers shared by the converter rtl
`ifndef RGB_CMY_HSB_COLOR_CONVERTER_DEFINES_SVH
`define RGB_CMY_HSB_COLOR_CONVERTER_DEFINES_SVH

// checked on every rising clock edge outside reset
`define CCV_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ccv check failed");

// implication form
`define CCV_ASSERT_IF(name, cond, prop) \
  `CCV_ASSERT(name, (cond) |-> (prop))

`endif

[sv/ccv_pkg.sv]
`default_nettype none

package ccv_pkg;

  localparam int unsigned COMPONENT_BITS = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    SPACE_RGB = 2'd0,
    SPACE_CMY = 2'd1,
    SPACE_HSB = 2'd2
  } space_e;

  // register index is address bit 2
  typedef enum logic {
    REG_SOURCE = 1'b0,
    REG_TARGET = 1'b1
  } reg_e;

  typedef struct packed {
    logic   bypass;
    logic   src_hsb;
    space_e dst;
  } mode_t;

  // the spare code behaves as rgb
  function automatic space_e norm_space(input logic [1:0] code);
    space_e sp;
    unique case (code)
      SPACE_CMY: sp = SPACE_CMY;
      SPACE_HSB: sp = SPACE_HSB;
      default:   sp = SPACE_RGB;
    endcase
    return sp;
  endfunction

endpackage

`default_nettype wire

[sv/ccv_front.sv]
`default_nettype none

module ccv_front import ccv_pkg::*; #(
  parameter int unsigned CW = COMPONENT_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [CW-1:0] a_i,
  input  wire logic [CW-1:0] b_i,
  input  wire logic [CW-1:0] c_i,
  input  wire logic [1:0]    source_i,
  input  wire logic [1:0]    target_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mode_t              mode_o,
  output logic [CW-1:0]      a_o,
  output logic [CW-1:0]      b_o,
  output logic [CW-1:0]      c_o
);

  space_e        src, dst;
  mode_t         mode_d, mode_q;
  logic [CW-1:0] a_d, b_d, c_d, a_q, b_q, c_q;
  logic          valid_d, valid_q;

  always_comb begin
    src            = norm_space(source_i);
    dst            = norm_space(target_i);
    mode_d.bypass  = (src == dst);
    mode_d.src_hsb = (src == SPACE_HSB);
    mode_d.dst     = dst;
    // cmy enters the back end already as rgb unless the beat is a bypass
    if (src == SPACE_CMY && !mode_d.bypass) begin
      a_d = ~a_i;
      b_d = ~b_i;
      c_d = ~c_i;
    end else begin
      a_d = a_i;
      b_d = b_i;
      c_d = c_i;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_d;
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
    end
  end

  assign out_valid_o = valid_q;
  assign mode_o      = mode_q;
  assign a_o         = a_q;
  assign b_o         = b_q;
  assign c_o         = c_q;

endmodule

`default_nettype wire

[sv/ccv_fifo.sv]
`default_nettype none

module ccv_fifo import ccv_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL = NW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[sv/ccv_div.sv]
`default_nettype none

// restoring divider, one quotient bit per stage; needs num < den * 2^Q_W
module ccv_div #(
  parameter int unsigned DEN_W = 16,
  parameter int unsigned Q_W   = 16
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [DEN_W-1:0] num_hi_i,
  input  wire logic [Q_W-1:0]   num_lo_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]        quo_o
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   lo_q  [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_in, den_in;
    logic [Q_W-1:0]   lo_in, quo_in;
    logic [DEN_W+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = num_hi_i;
      assign den_in = den_i;
      assign lo_in  = num_lo_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {1'b0, rem_in, lo_in[Q_W-1]} - {2'b00, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        lo_q[k]  <= {lo_in[Q_W-2:0], 1'b0};
        if (!trial[DEN_W+1]) begin
          rem_q[k] <= trial[DEN_W-1:0];
          quo_q[k] <= {quo_in[Q_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= {rem_in[DEN_W-2:0], lo_in[Q_W-1]};
          quo_q[k] <= {quo_in[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

`default_nettype wire

[sv/ccv_back.sv]
`default_nettype none

module ccv_back import ccv_pkg::*; #(
  parameter int unsigned CW = COMPONENT_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mode_t         mode_i,
  input  wire logic [CW-1:0] a_i,
  input  wire logic [CW-1:0] b_i,
  input  wire logic [CW-1:0] c_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [CW-1:0]      result_a_o,
  output logic [CW-1:0]      result_b_o,
  output logic [CW-1:0]      result_c_o
);

  localparam int unsigned PW  = 2 * CW;
  localparam int unsigned LAT = 7 + CW;
  localparam int unsigned MW  = $bits(mode_t);
  localparam int unsigned SW  = MW + 1 + 4 * CW;
  localparam logic [CW-1:0] FS = {CW{1'b1}};

  // floor(x / FS) for x <= FS*FS
  function automatic logic [CW-1:0] div_fs(input logic [PW-1:0] x);
    logic [CW-1:0] q0, inc;
    logic [CW:0]   r;
    q0 = x[PW-1:CW];
    r  = {1'b0, x[CW-1:0]} + {1'b0, q0};
    if (r >= {FS, 1'b0}) begin
      inc = CW'(2);
    end else if (r >= {1'b0, FS}) begin
      inc = CW'(1);
    end else begin
      inc = '0;
    end
    return q0 + inc;
  endfunction

  logic adv;
  logic [LAT-1:0] vld_q;
  logic out_valid_q;

  // the whole pipe moves whenever the output register can take a beat
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: hue sector and fraction
  logic [CW+2:0] scaled;
  logic [2:0]    q0, sec_d;
  logic [CW:0]   rsum;
  logic [CW-1:0] fr_d;
  mode_t         s1_mode_q;
  logic [2:0]    s1_sec_q;
  logic [CW-1:0] s1_fr_q, s1_s_q, s1_v_q, s1_a_q, s1_b_q, s1_c_q;

  always_comb begin
    scaled = ({3'b000, a_i} << 2) + ({3'b000, a_i} << 1);
    q0     = scaled[CW+2:CW];
    rsum   = {1'b0, scaled[CW-1:0]} + {{(CW-2){1'b0}}, q0};
    if (rsum >= {1'b0, FS}) begin
      sec_d = q0 + 3'd1;
      fr_d  = rsum[CW-1:0] - FS;
    end else begin
      sec_d = q0;
      fr_d  = rsum[CW-1:0];
    end
    // a full turn wraps to sector zero
    if (sec_d >= 3'd6) begin
      sec_d = '0;
      fr_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mode_q <= mode_i;
      s1_sec_q  <= sec_d;
      s1_fr_q   <= fr_d;
      s1_s_q    <= b_i;
      s1_v_q    <= c_i;
      s1_a_q    <= a_i;
      s1_b_q    <= b_i;
      s1_c_q    <= c_i;
    end
  end

  // stage 2: saturation times fraction and times its complement
  mode_t         s2_mode_q;
  logic [2:0]    s2_sec_q;
  logic          s2_szero_q;
  logic [PW-1:0] s2_m1_q, s2_m2_q;
  logic [CW-1:0] s2_k0_q, s2_v_q, s2_a_q, s2_b_q, s2_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_mode_q  <= s1_mode_q;
      s2_sec_q   <= s1_sec_q;
      s2_szero_q <= (s1_s_q == '0);
      s2_m1_q    <= {{CW{1'b0}}, s1_s_q} * {{CW{1'b0}}, s1_fr_q};
      s2_m2_q    <= {{CW{1'b0}}, s1_s_q} * {{CW{1'b0}}, FS - s1_fr_q};
      s2_k0_q    <= FS - s1_s_q;
      s2_v_q     <= s1_v_q;
      s2_a_q     <= s1_a_q;
      s2_b_q     <= s1_b_q;
      s2_c_q     <= s1_c_q;
    end
  end

  // stage 3: factors for q and t
  mode_t         s3_mode_q;
  logic [2:0]    s3_sec_q;
  logic          s3_szero_q;
  logic [CW-1:0] s3_k0_q, s3_k1_q, s3_k2_q, s3_v_q, s3_a_q, s3_b_q, s3_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_mode_q  <= s2_mode_q;
      s3_sec_q   <= s2_sec_q;
      s3_szero_q <= s2_szero_q;
      s3_k0_q    <= s2_k0_q;
      s3_k1_q    <= FS - div_fs(s2_m1_q);
      s3_k2_q    <= FS - div_fs(s2_m2_q);
      s3_v_q     <= s2_v_q;
      s3_a_q     <= s2_a_q;
      s3_b_q     <= s2_b_q;
      s3_c_q     <= s2_c_q;
    end
  end

  // stage 4: brightness products
  mode_t         s4_mode_q;
  logic [2:0]    s4_sec_q;
  logic          s4_szero_q;
  logic [PW-1:0] s4_pp_q, s4_qq_q, s4_tt_q;
  logic [CW-1:0] s4_v_q, s4_a_q, s4_b_q, s4_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_mode_q  <= s3_mode_q;
      s4_sec_q   <= s3_sec_q;
      s4_szero_q <= s3_szero_q;
      s4_pp_q    <= {{CW{1'b0}}, s3_v_q} * {{CW{1'b0}}, s3_k0_q};
      s4_qq_q    <= {{CW{1'b0}}, s3_v_q} * {{CW{1'b0}}, s3_k1_q};
      s4_tt_q    <= {{CW{1'b0}}, s3_v_q} * {{CW{1'b0}}, s3_k2_q};
      s4_v_q     <= s3_v_q;
      s4_a_q     <= s3_a_q;
      s4_b_q     <= s3_b_q;
      s4_c_q     <= s3_c_q;
    end
  end

  // stage 5: sector select into rgb, or pass-through for bypass or a non-hsb source
  logic [CW-1:0] p, q, t, r5, g5, b5;
  mode_t         s5_mode_q;
  logic [CW-1:0] s5_r_q, s5_g_q, s5_b_q;

  always_comb begin
    p = div_fs(s4_pp_q);
    q = div_fs(s4_qq_q);
    t = div_fs(s4_tt_q);
    case (s4_sec_q)
      3'd0:    begin r5 = s4_v_q; g5 = t;      b5 = p;      end
      3'd1:    begin r5 = q;      g5 = s4_v_q; b5 = p;      end
      3'd2:    begin r5 = p;      g5 = s4_v_q; b5 = t;      end
      3'd3:    begin r5 = p;      g5 = q;      b5 = s4_v_q; end
      3'd4:    begin r5 = t;      g5 = p;      b5 = s4_v_q; end
      default: begin r5 = s4_v_q; g5 = p;      b5 = q;      end
    endcase
    if (s4_szero_q) begin
      r5 = s4_v_q;
      g5 = s4_v_q;
      b5 = s4_v_q;
    end
    if (s4_mode_q.bypass || !s4_mode_q.src_hsb) begin
      r5 = s4_a_q;
      g5 = s4_b_q;
      b5 = s4_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_mode_q <= s4_mode_q;
      s5_r_q    <= r5;
      s5_g_q    <= g5;
      s5_b_q    <= b5;
    end
  end

  // stage 6: max, min, spread
  logic [CW-1:0] mx, mn;
  mode_t         s6_mode_q;
  logic [CW-1:0] s6_mx_q, s6_delta_q, s6_r_q, s6_g_q, s6_b_q;
  logic          s6_rmax_q, s6_gmax_q;

  always_comb begin
    mx = s5_r_q;
    mn = s5_r_q;
    if (s5_g_q > mx) mx = s5_g_q;
    if (s5_b_q > mx) mx = s5_b_q;
    if (s5_g_q < mn) mn = s5_g_q;
    if (s5_b_q < mn) mn = s5_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_mode_q  <= s5_mode_q;
      s6_mx_q    <= mx;
      s6_delta_q <= mx - mn;
      s6_rmax_q  <= (s5_r_q == mx);
      s6_gmax_q  <= (s5_g_q == mx);
      s6_r_q     <= s5_r_q;
      s6_g_q     <= s5_g_q;
      s6_b_q     <= s5_b_q;
    end
  end

  // stage 7: hue numerator in sixths of a turn, divider operands
  logic [CW+2:0]  d6, n, rx, gx, bx, dx;
  logic [PW-1:0]  num_s_d;
  logic [PW+2:0]  num_h_d;
  mode_t          s7_mode_q;
  logic           s7_zero_q;
  logic [PW-1:0]  s7_num_s_q;
  logic [PW+2:0]  s7_num_h_q;
  logic [CW+2:0]  s7_d6_q;
  logic [CW-1:0]  s7_mx_q, s7_r_q, s7_g_q, s7_b_q;

  always_comb begin
    rx = {3'b000, s6_r_q};
    gx = {3'b000, s6_g_q};
    bx = {3'b000, s6_b_q};
    dx = {3'b000, s6_delta_q};
    d6 = (dx << 2) + (dx << 1);
    if (s6_rmax_q) begin
      n = (s6_g_q >= s6_b_q) ? gx - bx : d6 + gx - bx;
    end else if (s6_gmax_q) begin
      n = (dx << 1) + bx - rx;
    end else begin
      n = (dx << 2) + rx - gx;
    end
    num_s_d = {s6_delta_q, {CW{1'b0}}} - {{CW{1'b0}}, s6_delta_q};
    num_h_d = {n, {CW{1'b0}}} - {{CW{1'b0}}, n};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_mode_q  <= s6_mode_q;
      s7_zero_q  <= (s6_delta_q == '0);
      s7_num_s_q <= num_s_d;
      s7_num_h_q <= num_h_d;
      s7_d6_q    <= d6;
      s7_mx_q    <= s6_mx_q;
      s7_r_q     <= s6_r_q;
      s7_g_q     <= s6_g_q;
      s7_b_q     <= s6_b_q;
    end
  end

  // dividers for saturation and hue
  logic [CW-1:0] sat_quo, hue_quo;

  ccv_div #(
    .DEN_W (CW),
    .Q_W   (CW)
  ) u_div_sat (
    .clk_i    (clk_i),
    .en_i     (adv),
    .num_hi_i (s7_num_s_q[PW-1:CW]),
    .num_lo_i (s7_num_s_q[CW-1:0]),
    .den_i    (s7_mx_q),
    .quo_o    (sat_quo)
  );

  ccv_div #(
    .DEN_W (CW + 3),
    .Q_W   (CW)
  ) u_div_hue (
    .clk_i    (clk_i),
    .en_i     (adv),
    .num_hi_i (s7_num_h_q[PW+2:CW]),
    .num_lo_i (s7_num_h_q[CW-1:0]),
    .den_i    (s7_d6_q),
    .quo_o    (hue_quo)
  );

  // side data rides along with the divider
  logic [SW-1:0] side_q [CW];
  logic [SW-1:0] side_in, side_out;

  assign side_in  = {s7_mode_q, s7_zero_q, s7_mx_q, s7_r_q, s7_g_q, s7_b_q};
  assign side_out = side_q[CW-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < CW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // output selection
  mode_t         f_mode;
  logic          f_zero;
  logic [CW-1:0] f_mx, f_r, f_g, f_b, ra_d, rb_d, rc_d;
  logic [CW-1:0] ra_q, rb_q, rc_q;

  always_comb begin
    {f_mode, f_zero, f_mx, f_r, f_g, f_b} = side_out;
    ra_d = f_r;
    rb_d = f_g;
    rc_d = f_b;
    if (!f_mode.bypass) begin
      case (f_mode.dst)
        SPACE_CMY: begin
          ra_d = ~f_r;
          rb_d = ~f_g;
          rc_d = ~f_b;
        end
        SPACE_HSB: begin
          ra_d = f_zero ? '0 : hue_quo;
          rb_d = f_zero ? '0 : sat_quo;
          rc_d = f_mx;
        end
        default: begin
          ra_d = f_r;
          rb_d = f_g;
          rc_d = f_b;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[LAT-2:0], in_valid_i};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra_q <= ra_d;
      rb_q <= rb_d;
      rc_q <= rc_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_a_o  = ra_q;
  assign result_b_o  = rb_q;
  assign result_c_o  = rc_q;

endmodule

`default_nettype wire

[sv/rgb_cmy_hsb_color_converter.sv]
// throughput: one color per cycle unless the output stalls; the back end
// moves as a single stalled pipe whose depth is set by the two
// bit-per-stage dividers for saturation and hue
// reset: asynchronous, active low; both space registers return to rgb and
// all queued and in-flight beats are dropped
`default_nettype none
`include "rgb_cmy_hsb_color_converter_defines.svh"

module rgb_cmy_hsb_color_converter import ccv_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = ccv_pkg::COMPONENT_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [COMPONENT_BITS-1:0] component_a_i,
  input  wire logic [COMPONENT_BITS-1:0] component_b_i,
  input  wire logic [COMPONENT_BITS-1:0] component_c_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [COMPONENT_BITS-1:0]      result_a_o,
  output logic [COMPONENT_BITS-1:0]      result_b_o,
  output logic [COMPONENT_BITS-1:0]      result_c_o
);

  localparam int unsigned CW = COMPONENT_BITS;
  localparam int unsigned FW = $bits(mode_t) + 3 * CW;

  logic [1:0] source_q, target_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= SPACE_RGB;
      target_q <= SPACE_RGB;
    end else if (wr_en) begin
      if (paddr[2] == REG_SOURCE) begin
        source_q <= pwdata[1:0];
      end else begin
        target_q <= pwdata[1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SOURCE) ? {30'd0, source_q} : {30'd0, target_q};

  // front: classify and register the beat
  logic          fr_valid, fr_ready;
  mode_t         fr_mode;
  logic [CW-1:0] fr_a, fr_b, fr_c;

  ccv_front #(
    .CW (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_i         (component_a_i),
    .b_i         (component_b_i),
    .c_i         (component_c_i),
    .source_i    (source_q),
    .target_i    (target_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .mode_o      (fr_mode),
    .a_o         (fr_a),
    .b_o         (fr_b),
    .c_o         (fr_c)
  );

  logic          q_valid, q_ready;
  logic [FW-1:0] q_data;
  mode_t         q_mode;
  logic [CW-1:0] q_a, q_b, q_c;

  ccv_fifo #(
    .WIDTH (FW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  ({fr_mode, fr_a, fr_b, fr_c}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign {q_mode, q_a, q_b, q_c} = q_data;

  ccv_back #(
    .CW (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .mode_i      (q_mode),
    .a_i         (q_a),
    .b_i         (q_b),
    .c_i         (q_c),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_a_o  (result_a_o),
    .result_b_o  (result_b_o),
    .result_c_o  (result_c_o)
  );

  // result beat while the space registers select hsb from another space
  logic hsb_beat;

  assign hsb_beat = out_valid_o && target_q == SPACE_HSB && source_q != SPACE_HSB;

  `CCV_ASSERT_IF(a_hue_below_turn, hsb_beat, result_a_o != '1)
  `CCV_ASSERT_IF(a_black_no_hue, hsb_beat && result_c_o == '0, result_a_o == '0 && result_b_o == '0)
  `CCV_ASSERT_IF(a_source_write, wr_en && paddr[2] == REG_SOURCE, ##1 source_q == $past(pwdata[1:0]))

endmodule

`default_nettype wire
